@@ rtl/pclb_pkg.sv @@
package pclb_pkg;

    // Sizes of the grid and of the particle store
    localparam int MAX_SIDE      = 16;
    localparam int MAX_PARTICLES = 1024;
    localparam int CELL_DEPTH    = MAX_SIDE * MAX_SIDE * MAX_SIDE;

    // Field and register widths
    localparam int POS_W   = 32;
    localparam int BOX_W   = 31;
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int COORD_W = $clog2(MAX_SIDE);
    localparam int NSQ_W   = $clog2(MAX_SIDE * MAX_SIDE + 1);
    localparam int CELL_W  = $clog2(CELL_DEPTH);
    localparam int PART_W  = $clog2(MAX_PARTICLES);
    localparam int CNT_W   = PART_W + 1;
    localparam int HEAD_W  = PART_W + 1;
    localparam int PROD_W  = BOX_W + SIDE_W;
    localparam int STEP_W  = $clog2(POS_W);
    localparam int CFG_W   = BOX_W;
    localparam int IDX_W   = 1;

    // Output field widths fixed by the interface
    localparam int PIDX_OUT_W = 10;
    localparam int CELL_OUT_W = 12;

    // Register reset values
    localparam logic [BOX_W-1:0]  BOX_RESET   = BOX_W'(1048576);
    localparam logic [SIDE_W-1:0] CELLS_RESET = SIDE_W'(4);

    // Register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_BOX_SIZE       = 1'b0;
    localparam logic [IDX_W-1:0] REG_CELLS_PER_SIDE = 1'b1;

    // Input item kinds
    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    // Sequencer of the top level
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIN,
        ST_READ,
        ST_WRITE
    } top_state_t;

    // Sequencer of one axis unit
    typedef enum logic [2:0] {
        AX_IDLE,
        AX_MOD,
        AX_FIX,
        AX_MUL,
        AX_SCALE,
        AX_DONE
    } axis_state_t;

    // Status and result of one axis unit
    typedef struct packed {
        logic               done;
        logic [BOX_W-1:0]   wrapped;
        logic [COORD_W-1:0] coord;
    } axis_res_t;

endpackage

@@ rtl/pclb_ram.sv @@
module pclb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/pclb_axis.sv @@
module pclb_axis (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [pclb_pkg::POS_W-1:0] pos,
    input  logic [pclb_pkg::BOX_W-1:0]        box,
    input  logic [pclb_pkg::SIDE_W-1:0]       nsat,
    output pclb_pkg::axis_res_t               res
);

    pclb_pkg::axis_state_t state_reg, state_next;

    logic [pclb_pkg::STEP_W-1:0]  cnt_reg;
    logic [pclb_pkg::POS_W-1:0]   dvd_reg;
    logic [pclb_pkg::BOX_W-1:0]   rem_reg;
    logic [pclb_pkg::BOX_W-1:0]   w_reg;
    logic [pclb_pkg::COORD_W-1:0] q_reg;
    logic                         neg_reg;

    logic [pclb_pkg::BOX_W:0]      trial;
    logic                          ge;
    logic [pclb_pkg::BOX_W-1:0]    rem_next;
    logic [pclb_pkg::BOX_W-1:0]    w_next;
    logic [pclb_pkg::PROD_W-1:0]   prod;
    logic [pclb_pkg::POS_W-1:0]    mag;
    logic                          box_zero;

    assign box_zero = (box == '0);

    // One restoring step: shift in the next dividend bit, subtract the box if it fits.
    assign trial    = {rem_reg, dvd_reg[pclb_pkg::POS_W-1]};
    assign ge       = (trial >= {1'b0, box});
    assign rem_next = ge ? pclb_pkg::BOX_W'(trial - {1'b0, box})
                         : trial[pclb_pkg::BOX_W-1:0];

    // Magnitude of the signed position; the most negative value maps to 2^31.
    assign mag = pos[pclb_pkg::POS_W-1] ? pclb_pkg::POS_W'(-pos) : pclb_pkg::POS_W'(pos);

    // A negative position with a nonzero remainder folds to box minus remainder.
    always_comb begin
        if (box_zero) begin
            w_next = '0;
        end else if (neg_reg && (rem_reg != '0)) begin
            w_next = box - rem_reg;
        end else begin
            w_next = rem_reg;
        end
    end

    assign prod = pclb_pkg::PROD_W'(w_reg) * pclb_pkg::PROD_W'(nsat);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pclb_pkg::AX_IDLE:  if (start) state_next = pclb_pkg::AX_MOD;
            pclb_pkg::AX_MOD:   if (cnt_reg == '0) state_next = pclb_pkg::AX_FIX;
            pclb_pkg::AX_FIX:   state_next = pclb_pkg::AX_MUL;
            pclb_pkg::AX_MUL:   state_next = pclb_pkg::AX_SCALE;
            pclb_pkg::AX_SCALE: if (cnt_reg == '0) state_next = pclb_pkg::AX_DONE;
            pclb_pkg::AX_DONE:  state_next = pclb_pkg::AX_IDLE;
            default:            state_next = pclb_pkg::AX_IDLE;
        endcase
    end

    // Outputs; the results hold until the next start.
    always_comb begin
        res.done    = (state_reg == pclb_pkg::AX_DONE);
        res.wrapped = w_reg;
        res.coord   = box_zero ? '0 : q_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pclb_pkg::AX_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath: the remainder loop, the fold, and the short scaling divide.
    always_ff @(posedge aclk) begin
        case (state_reg)
            pclb_pkg::AX_IDLE: begin
                if (start) begin
                    neg_reg <= pos[pclb_pkg::POS_W-1];
                    dvd_reg <= mag;
                    rem_reg <= '0;
                    cnt_reg <= pclb_pkg::STEP_W'(pclb_pkg::POS_W - 1);
                end
            end
            pclb_pkg::AX_MOD: begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[pclb_pkg::POS_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 1'b1;
            end
            pclb_pkg::AX_FIX: begin
                w_reg <= w_next;
            end
            pclb_pkg::AX_MUL: begin
                // The quotient stays below 2^COORD_W, so the upper product bits
                // already form a partial remainder below the box.
                rem_reg <= prod[pclb_pkg::COORD_W +: pclb_pkg::BOX_W];
                dvd_reg <= {prod[pclb_pkg::COORD_W-1:0],
                            {(pclb_pkg::POS_W - pclb_pkg::COORD_W){1'b0}}};
                q_reg   <= '0;
                cnt_reg <= pclb_pkg::STEP_W'(pclb_pkg::COORD_W - 1);
            end
            pclb_pkg::AX_SCALE: begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[pclb_pkg::POS_W-2:0], 1'b0};
                q_reg   <= {q_reg[pclb_pkg::COORD_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/periodic_cell_list_binner.sv @@
// Channel   Direction  Transaction
// s_        in         one item: start a build (mode 0) or insert a particle (mode 1)
// m_        out        one result per insert, none per start
// cfg_      in         register write, taken at once, no read-back
//
// An insert passes through these steps before its result is loaded: 32 one-bit remainder steps
// in each of the three axis units, a fold step, a multiply step, a four-step
// scaling divide, forming the cell index, and a read and write of the head
// memory. The next item is accepted in the cycle after the result is loaded.
// A start item and reset both run a clearing pass over all 4096 cell heads,
// one per cycle, with s_tready low; configuration writes are taken throughout.
// A result waits in the output register while m_tready is low; the next item is
// accepted once that result has been loaded.
module periodic_cell_list_binner (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port
    input  logic                          cfg_we,
    input  logic [pclb_pkg::IDX_W-1:0]    cfg_index,
    input  logic [pclb_pkg::CFG_W-1:0]    cfg_data,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [95:0]                   s_tdata,   // pos_x, pos_y, pos_z
    input  logic                          s_tuser,   // mode
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [127:0]                  m_tdata,   // particle_index, cell_index,
                                                     // wrapped_x, wrapped_y, wrapped_z,
                                                     // previous_head, zero fill
    output logic [1:0]                    m_tuser    // previous_valid, overflow
);

    pclb_pkg::top_state_t state_reg, state_next;

    logic [pclb_pkg::BOX_W-1:0]   box_reg;
    logic [pclb_pkg::SIDE_W-1:0]  cells_reg;
    logic [pclb_pkg::SIDE_W-1:0]  n_reg;
    logic [pclb_pkg::NSQ_W-1:0]   nsq_reg;
    logic [pclb_pkg::SIDE_W-1:0]  n_next;
    logic [pclb_pkg::CELL_W-1:0]  clr_addr_reg;
    logic [pclb_pkg::CNT_W-1:0]   count_reg;
    logic [pclb_pkg::CELL_W-1:0]  cell_reg;
    logic [pclb_pkg::CELL_W-1:0]  cell_next;

    logic                               out_valid_reg;
    logic [pclb_pkg::PIDX_OUT_W-1:0]    pidx_reg;
    logic [pclb_pkg::CELL_OUT_W-1:0]    cell_out_reg;
    logic [pclb_pkg::BOX_W-1:0]         wx_reg, wy_reg, wz_reg;
    logic [pclb_pkg::PIDX_OUT_W-1:0]    phead_reg;
    logic                               pvalid_reg;
    logic                               ovf_reg;

    logic        accept;
    logic        axis_start;
    logic        out_free;
    logic        full;
    logic        commit;

    pclb_pkg::axis_res_t res_x, res_y, res_z;

    logic                          head_we;
    logic [pclb_pkg::CELL_W-1:0]   head_waddr;
    logic [pclb_pkg::HEAD_W-1:0]   head_wdata;
    logic                          head_re;
    logic [pclb_pkg::HEAD_W-1:0]   head_rdata;
    logic                          next_we;

    assign accept     = s_tvalid && s_tready;
    assign axis_start = accept && (s_tuser == pclb_pkg::MODE_INSERT);
    assign out_free   = !out_valid_reg || m_tready;
    assign full       = count_reg[pclb_pkg::PART_W];
    assign commit     = (state_reg == pclb_pkg::ST_WRITE) && out_free;

    // Cells per side folded into 1 .. MAX_SIDE.
    always_comb begin
        if (cells_reg == '0) begin
            n_next = pclb_pkg::SIDE_W'(1);
        end else if (cells_reg > pclb_pkg::SIDE_W'(pclb_pkg::MAX_SIDE)) begin
            n_next = pclb_pkg::SIDE_W'(pclb_pkg::MAX_SIDE);
        end else begin
            n_next = cells_reg;
        end
    end

    // Flat cell index from the three axis coordinates.
    assign cell_next = pclb_pkg::CELL_W'(res_x.coord) * pclb_pkg::CELL_W'(nsq_reg)
                     + pclb_pkg::CELL_W'(res_y.coord) * pclb_pkg::CELL_W'(n_reg)
                     + pclb_pkg::CELL_W'(res_z.coord);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg   <= pclb_pkg::BOX_RESET;
            cells_reg <= pclb_pkg::CELLS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                pclb_pkg::REG_BOX_SIZE:       box_reg   <= cfg_data;
                pclb_pkg::REG_CELLS_PER_SIDE: cells_reg <= cfg_data[pclb_pkg::SIDE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Three axis units working in lockstep
    pclb_axis u_axis_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (axis_start),
        .pos     (s_tdata[31:0]),
        .box     (box_reg),
        .nsat    (n_reg),
        .res     (res_x)
    );

    pclb_axis u_axis_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (axis_start),
        .pos     (s_tdata[63:32]),
        .box     (box_reg),
        .nsat    (n_reg),
        .res     (res_y)
    );

    pclb_axis u_axis_z (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (axis_start),
        .pos     (s_tdata[95:64]),
        .box     (box_reg),
        .nsat    (n_reg),
        .res     (res_z)
    );

    // Cell heads: valid flag over particle number
    pclb_ram #(
        .WIDTH (pclb_pkg::HEAD_W),
        .DEPTH (pclb_pkg::CELL_DEPTH)
    ) u_head_ram (
        .aclk    (aclk),
        .wr_en   (head_we),
        .wr_addr (head_waddr),
        .wr_data (head_wdata),
        .rd_en   (head_re),
        .rd_addr (cell_reg),
        .rd_data (head_rdata)
    );

    // Successor links, written on every stored insert
    pclb_ram #(
        .WIDTH (pclb_pkg::HEAD_W),
        .DEPTH (pclb_pkg::MAX_PARTICLES)
    ) u_next_ram (
        .aclk    (aclk),
        .wr_en   (next_we),
        .wr_addr (count_reg[pclb_pkg::PART_W-1:0]),
        .wr_data (head_rdata),
        .rd_en   (1'b0),
        .rd_addr ('0),
        .rd_data ()
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pclb_pkg::ST_CLEAR: begin
                if (clr_addr_reg == pclb_pkg::CELL_W'(pclb_pkg::CELL_DEPTH - 1)) begin
                    state_next = pclb_pkg::ST_IDLE;
                end
            end
            pclb_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_tuser == pclb_pkg::MODE_INSERT) ? pclb_pkg::ST_BIN
                                                                    : pclb_pkg::ST_CLEAR;
                end
            end
            pclb_pkg::ST_BIN:   if (res_x.done) state_next = pclb_pkg::ST_READ;
            pclb_pkg::ST_READ:  state_next = pclb_pkg::ST_WRITE;
            pclb_pkg::ST_WRITE: if (out_free) state_next = pclb_pkg::ST_IDLE;
            default:            state_next = pclb_pkg::ST_CLEAR;
        endcase
    end

    // Outputs of the sequencer: handshake and memory controls
    always_comb begin
        s_tready   = (state_reg == pclb_pkg::ST_IDLE);
        head_re    = (state_reg == pclb_pkg::ST_READ);
        head_we    = 1'b0;
        head_waddr = cell_reg;
        head_wdata = {1'b1, count_reg[pclb_pkg::PART_W-1:0]};
        next_we    = 1'b0;
        case (state_reg)
            pclb_pkg::ST_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_addr_reg;
                head_wdata = '0;
            end
            pclb_pkg::ST_WRITE: begin
                head_we = commit && !full;
                next_we = commit && !full;
            end
            default: begin
            end
        endcase
    end

    // Sequencer, clearing counter and particle counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pclb_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == pclb_pkg::ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (accept && (s_tuser == pclb_pkg::MODE_START)) begin
                count_reg <= '0;
            end else if (commit && !full) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Per-item settings and the cell index
    always_ff @(posedge aclk) begin
        if (axis_start) begin
            n_reg   <= n_next;
            nsq_reg <= pclb_pkg::NSQ_W'(n_next) * pclb_pkg::NSQ_W'(n_next);
        end
        if ((state_reg == pclb_pkg::ST_BIN) && res_x.done) begin
            cell_reg <= cell_next;
        end
    end

    // Output register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (commit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (commit) begin
            pidx_reg     <= full ? '0 : count_reg[pclb_pkg::PIDX_OUT_W-1:0];
            cell_out_reg <= cell_reg;
            wx_reg       <= res_x.wrapped;
            wy_reg       <= res_y.wrapped;
            wz_reg       <= res_z.wrapped;
            pvalid_reg   <= !full && head_rdata[pclb_pkg::PART_W];
            phead_reg    <= (full || !head_rdata[pclb_pkg::PART_W])
                            ? '0 : head_rdata[pclb_pkg::PIDX_OUT_W-1:0];
            ovf_reg      <= full;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, phead_reg, wz_reg, wy_reg, wx_reg, cell_out_reg, pidx_reg};
    assign m_tuser  = {ovf_reg, pvalid_reg};

`ifndef SYNTHESIS
    // A result appears only from the write step of an insert.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == pclb_pkg::ST_WRITE))
        else $error("result loaded outside the write step");

    // A dropped item carries no particle number and no predecessor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && ovf_reg) |-> (!pvalid_reg && (pidx_reg == '0) && (phead_reg == '0)))
        else $error("overflow result with stored fields");

    // The particle counter never passes the store capacity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pclb_pkg::CNT_W'(pclb_pkg::MAX_PARTICLES))
        else $error("particle counter beyond capacity");

    // The three axis units finish in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_x.done == res_y.done) && (res_x.done == res_z.done))
        else $error("axis units out of step");
`endif

endmodule
